@@ src/cet_pkg.sv @@
// ----------------------------------------------------------------------------
// Cubic escape-time package
// Shared widths, register map, state and colour codes, and the fixed-point
// helper functions used by the register block and the iteration core.
// ----------------------------------------------------------------------------
package cet_pkg;

  // Fixed-point format of c and z, and width of the iteration counter.
  localparam int FRAC_BITS  = 27;
  localparam int ITER_WIDTH = 12;
  localparam int CPLX_W     = 32;
  localparam int CUT_W      = 31;
  localparam int PROD_W     = 2 * CPLX_W;

  // A scaled product keeps the bits above the fraction.
  localparam int MQ_W  = PROD_W - FRAC_BITS;
  // Accumulator holds a sum of two scaled products, z^2 and c.
  localparam int ACC_W = ((MQ_W > CPLX_W) ? MQ_W : CPLX_W) + 3;

  // Colour compares use k+1 times a small constant, and 11*k.
  localparam int CMP_W = ITER_WIDTH + 5;

  // Register map.
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_LSB   = 2;
  localparam int REG_IDX_W = PADDR_W - REG_LSB;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_CUTOFF   = REG_IDX_W'(1);

  localparam logic [ITER_WIDTH-1:0] MAX_ITER_RST = ITER_WIDTH'(100);
  localparam logic [CUT_W-1:0]      CUTOFF_RST   = CUT_W'(536870912);

  // Saturation bounds of a z component, in accumulator width.
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'({1'b0, {(CPLX_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  typedef struct packed {
    logic [ITER_WIDTH-1:0] max_iterations;
    logic [CUT_W-1:0]      cutoff_sq;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_CROSS,
    ST_RE_A,
    ST_IM_B,
    ST_RE_B,
    ST_IM_A,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    COL_BLACK  = 3'd0,
    COL_WHITE  = 3'd1,
    COL_YELLOW = 3'd2,
    COL_ORANGE = 3'd3,
    COL_RED    = 3'd4
  } colour_e;

  // Floor of a full product divided by 2^FRAC_BITS.
  function automatic logic signed [MQ_W-1:0] mulq(input logic signed [PROD_W-1:0] p);
    mulq = p[PROD_W-1:FRAC_BITS];
  endfunction

  // Clamp an accumulator value to the signed range of a z component.
  function automatic logic signed [CPLX_W-1:0] sat_c(input logic signed [ACC_W-1:0] v);
    logic signed [CPLX_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[CPLX_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[CPLX_W-1:0];
    end else begin
      r = v[CPLX_W-1:0];
    end
    return r;
  endfunction

  // Colour band of an iteration count k against limit n. A test k < n/d is
  // done as d*(k+1) <= n, and k < n/2.2 as 11*k < 5*n.
  function automatic colour_e colour_of(input logic [ITER_WIDTH-1:0] k,
                                        input logic [ITER_WIDTH-1:0] n);
    logic [CMP_W-1:0] k1;
    logic [CMP_W-1:0] kk;
    logic [CMP_W-1:0] nn;
    colour_e          c;
    kk = CMP_W'(k);
    nn = CMP_W'(n);
    k1 = kk + CMP_W'(1);
    if ((kk != '0) && (k1 * CMP_W'(5) <= nn)) begin
      c = COL_BLACK;
    end else if (k1 * CMP_W'(4) <= nn) begin
      c = COL_WHITE;
    end else if (k1 * CMP_W'(3) <= nn) begin
      c = COL_YELLOW;
    end else if (kk * CMP_W'(11) < nn * CMP_W'(5)) begin
      c = COL_ORANGE;
    end else if (kk < nn) begin
      c = COL_RED;
    end else begin
      c = COL_BLACK;
    end
    return c;
  endfunction

endpackage

@@ src/cet_regs.sv @@
// ----------------------------------------------------------------------------
// Cubic escape-time configuration registers
// APB-style register file holding the iteration limit and escape cutoff.
// ----------------------------------------------------------------------------
module cet_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cet_pkg::PADDR_W-1:0]  paddr,
  input  logic [cet_pkg::PDATA_W-1:0]  pwdata,
  output logic [cet_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output cet_pkg::cfg_t                cfg_o
);
  import cet_pkg::*;

  cfg_t                 cfg_q;
  cfg_t                 cfg_d;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:REG_LSB];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_MAX_ITER: cfg_d.max_iterations = pwdata[ITER_WIDTH-1:0];
        REG_CUTOFF:   cfg_d.cutoff_sq      = pwdata[CUT_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_ITER: prdata = PDATA_W'(cfg_q.max_iterations);
      REG_CUTOFF:   prdata = PDATA_W'(cfg_q.cutoff_sq);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_iterations <= MAX_ITER_RST;
      cfg_q.cutoff_sq      <= CUTOFF_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/cet_mul.sv @@
// ----------------------------------------------------------------------------
// Cubic escape-time shared multiplier
// Signed 32 by 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module cet_mul (
  input  logic                               clk_i,
  input  logic signed [cet_pkg::CPLX_W-1:0]  op_a_i,
  input  logic signed [cet_pkg::CPLX_W-1:0]  op_b_i,
  output logic signed [cet_pkg::PROD_W-1:0]  prod_o
);
  import cet_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_a_i) * PROD_W'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule

@@ src/cet_core.sv @@
// ----------------------------------------------------------------------------
// Cubic escape-time iteration core
// Sequencer that runs z = z^3 + z^2 + c through one shared multiplier and
// holds the finished result in an output register.
// ----------------------------------------------------------------------------
module cet_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cet_pkg::cfg_t                      cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [cet_pkg::CPLX_W-1:0]  c_real_i,
  input  logic signed [cet_pkg::CPLX_W-1:0]  c_imag_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [cet_pkg::ITER_WIDTH-1:0]     iter_count_o,
  output logic                               inside_res_o,
  output logic [2:0]                         colour_class_o
);
  import cet_pkg::*;

  state_e                   state_q, state_d;
  logic [ITER_WIDTH-1:0]    iter_q, iter_d;
  logic [ITER_WIDTH-1:0]    k_q, k_d;
  logic                     inside_q, inside_d;
  logic signed [CPLX_W-1:0] a_q, a_d, b_q, b_d;
  logic signed [CPLX_W-1:0] cr_q, cr_d, ci_q, ci_d;
  logic signed [CPLX_W-1:0] z2r_q, z2r_d, z2i_q, z2i_d;
  logic signed [PROD_W-1:0] sq_q, sq_d;
  logic signed [ACC_W-1:0]  acc_r_q, acc_r_d, acc_i_q, acc_i_d;
  logic                     out_valid_q, out_valid_d;
  logic [ITER_WIDTH-1:0]    iter_out_q, iter_out_d;
  logic                     inside_out_q, inside_out_d;
  colour_e                  colour_q, colour_d;

  logic signed [CPLX_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_mq;
  logic [PROD_W-1:0]        mag;
  logic                     escaped;

  cet_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  assign prod_mq = ACC_W'(mulq(prod));
  // Both squares are non-negative, so their sum fits 64 unsigned bits.
  assign mag     = PROD_W'(unsigned'(sq_q)) + PROD_W'(unsigned'(prod));
  assign escaped = (mag >> FRAC_BITS) >= PROD_W'(cfg_i.cutoff_sq);

  always_comb begin
    state_d      = state_q;
    iter_d       = iter_q;
    k_d          = k_q;
    inside_d     = inside_q;
    a_d          = a_q;
    b_d          = b_q;
    cr_d         = cr_q;
    ci_d         = ci_q;
    z2r_d        = z2r_q;
    z2i_d        = z2i_q;
    sq_d         = sq_q;
    acc_r_d      = acc_r_q;
    acc_i_d      = acc_i_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    iter_out_d   = iter_out_q;
    inside_out_d = inside_out_q;
    colour_d     = colour_q;
    op_a         = a_q;
    op_b         = a_q;
    in_ready_o   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cr_d    = c_real_i;
          ci_d    = c_imag_i;
          a_d     = '0;
          b_d     = '0;
          iter_d  = '0;
          state_d = ST_SQ_A;
        end
      end
      ST_SQ_A: begin
        if (iter_q == cfg_i.max_iterations) begin
          k_d      = iter_q;
          inside_d = 1'b1;
          state_d  = ST_DONE;
        end else begin
          state_d = ST_SQ_B;
        end
      end
      ST_SQ_B: begin
        sq_d    = prod;
        op_a    = b_q;
        op_b    = b_q;
        state_d = ST_CROSS;
      end
      ST_CROSS: begin
        z2r_d = sat_c(ACC_W'(mulq(sq_q)) - prod_mq);
        op_b  = b_q;
        if (escaped) begin
          k_d      = iter_q;
          inside_d = 1'b0;
          state_d  = ST_DONE;
        end else begin
          state_d = ST_RE_A;
        end
      end
      ST_RE_A: begin
        z2i_d   = sat_c(prod_mq <<< 1);
        acc_r_d = ACC_W'(z2r_q) + ACC_W'(cr_q);
        op_a    = z2r_q;
        state_d = ST_IM_B;
      end
      ST_IM_B: begin
        acc_r_d = acc_r_q + prod_mq;
        op_a    = z2i_q;
        op_b    = b_q;
        state_d = ST_RE_B;
      end
      ST_RE_B: begin
        acc_r_d = acc_r_q - prod_mq;
        acc_i_d = ACC_W'(z2i_q) + ACC_W'(ci_q);
        op_a    = z2r_q;
        op_b    = b_q;
        state_d = ST_IM_A;
      end
      ST_IM_A: begin
        acc_i_d = acc_i_q + prod_mq;
        a_d     = sat_c(acc_r_q);
        op_a    = z2i_q;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        b_d     = sat_c(acc_i_q + prod_mq);
        iter_d  = iter_q + ITER_WIDTH'(1);
        state_d = ST_SQ_A;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          iter_out_d   = k_q;
          inside_out_d = inside_q;
          colour_d     = colour_of(k_q, cfg_i.max_iterations);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q       <= iter_d;
    k_q          <= k_d;
    inside_q     <= inside_d;
    a_q          <= a_d;
    b_q          <= b_d;
    cr_q         <= cr_d;
    ci_q         <= ci_d;
    z2r_q        <= z2r_d;
    z2i_q        <= z2i_d;
    sq_q         <= sq_d;
    acc_r_q      <= acc_r_d;
    acc_i_q      <= acc_i_d;
    iter_out_q   <= iter_out_d;
    inside_out_q <= inside_out_d;
    colour_q     <= colour_d;
  end

  assign out_valid_o    = out_valid_q;
  assign iter_count_o   = iter_out_q;
  assign inside_res_o   = inside_out_q;
  assign colour_class_o = colour_q;

endmodule

@@ src/cubic_escape_time_iteration.sv @@
// ----------------------------------------------------------------------------
// Cubic escape-time iteration
// Escape-time test of one complex point under z = z^3 + z^2 + c.
// ----------------------------------------------------------------------------
// One request carries a point c in signed Q5.27. Starting from z = 0 the block
// tests |z|^2 against cutoff_sq and then updates z, at most max_iterations
// times, and returns the escape index (or max_iterations with inside_res set)
// together with a colour band. A single 32 by 32 multiplier does all the
// work: each update needs seven products and the escape test reuses the two
// squares; one update steps through SQ_A, SQ_B, CROSS, RE_A, IM_B, RE_B,
// IM_A and UPDATE in turn. The block takes no new request while a point
// is in progress and is ready again in the same cycle in which that point's
// result first appears. A finished result waiting in the output register does
// not hold up the next request, but the next result cannot move into the
// output register until the waiting one has been taken. The configuration
// registers sit at byte address 0 (max_iterations) and 4 (cutoff_sq) and
// must only be written while no request is outstanding.
// ----------------------------------------------------------------------------
module cubic_escape_time_iteration (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cet_pkg::PADDR_W-1:0]        paddr,
  input  logic [cet_pkg::PDATA_W-1:0]        pwdata,
  output logic [cet_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready,
  // Point requests.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [cet_pkg::CPLX_W-1:0]  c_real_i,
  input  logic signed [cet_pkg::CPLX_W-1:0]  c_imag_i,
  // Results.
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [cet_pkg::ITER_WIDTH-1:0]     iter_count_o,
  output logic                               inside_res_o,
  output logic [2:0]                         colour_class_o
);
  import cet_pkg::*;

  cfg_t cfg;

  // The register block presents both settings as one struct to the core.
  cet_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The core sequences the shared multiplier and owns the result register.
  cet_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .c_real_i       (c_real_i),
    .c_imag_i       (c_imag_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .iter_count_o   (iter_count_o),
    .inside_res_o   (inside_res_o),
    .colour_class_o (colour_class_o)
  );

  // A taken request keeps the block busy for at least the next cycle.
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("block ready right after taking a request");

  // An inside result always reports the full iteration limit.
  a_inside_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && inside_res_o) |-> (iter_count_o == cfg.max_iterations))
    else $error("inside result with count other than the limit");

  // An escaped point must have escaped before reaching the limit.
  a_escape_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !inside_res_o) |-> (iter_count_o < cfg.max_iterations))
    else $error("escaped result with count at or above the limit");

  // Points inside the set are always drawn black.
  a_inside_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && inside_res_o) |-> (colour_class_o == COL_BLACK))
    else $error("inside result not in the black band");

endmodule
